// ----- sv/vct_pkg.sv -----
// shared types and constants for the view cone test block
package vct_pkg;

  localparam int MaxDim   = 8;
  localparam int CoordW   = 16;
  localparam int CntW     = $clog2(MaxDim + 1);
  localparam int DiffW    = CoordW + 1;
  localparam int DotW     = 32 + $clog2(MaxDim);
  localparam int SqW      = DotW + 1;
  localparam int MagW     = CoordW;
  localparam int C2W      = 2 * CoordW - 1;
  localparam int AccW     = 2 * DotW;
  localparam int LimbW    = 17;
  localparam int MulW     = LimbW + 1;
  localparam int ProdW    = 2 * MulW;
  localparam int DotLimbs = (DotW + LimbW - 1) / LimbW;
  localparam int SqLimbs  = (SqW + LimbW - 1) / LimbW;
  localparam int C2Limbs  = (C2W + LimbW - 1) / LimbW;
  localparam int DotPadW  = DotLimbs * LimbW;
  localparam int SqPadW   = SqLimbs * LimbW;
  localparam int C2PadW   = C2Limbs * LimbW;
  localparam int IdxW     = $clog2(SqLimbs);
  localparam int SumW     = IdxW + 1;
  localparam int ShiftW   = $clog2(AccW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_SQ,
    S_PREP,
    S_LHS,
    S_RHS,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DOT,
    OP_SQ,
    OP_C2,
    OP_LHS,
    OP_RHS
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [SumW-1:0] sum;
  } mul_tag_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] a_idx;
    logic [IdxW-1:0] b_idx;
    logic            in_ready;
    logic            prep;
    logic            finish;
  } seq_ctrl_t;

endpackage

// ----- sv/view_cone_test_unit.sv -----
// top level of the view cone test block: accumulators, operand select, result register
//
// A query is a run of requests on the input channel (in_valid_i / in_ready_o),
// one coordinate each: observer, target and direction, with last_i on the
// final coordinate. Each coordinate uses the one shared 18x18 multiplier twice
// (offset times direction, then offset squared), so within a query a new
// coordinate can be taken while the offset square of the previous one is issued.
// After the last coordinate the block squares the dot product and multiplies
// the squared cosine by the squared distance in 17-bit limbs on the same
// multiplier: 9 + 6 partial products plus setup and drain before the result
// request appears.
// Each query gives exactly one result request on the output channel
// (out_valid_o / out_ready_i). The result sits in an output register; the
// block goes back to idle and takes the next query while it waits, and only
// holds off at the end of the following query if it is still not taken.
// cos_half_angle_i is written whenever cos_half_angle_we_i is high; write it
// only while no query is in progress. Reset clears the cosine to zero, the
// accumulators and the output valid.
module view_cone_test_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cos_half_angle_we_i,
  input  logic signed [vct_pkg::CoordW-1:0]  cos_half_angle_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vct_pkg::CoordW-1:0]  observer_coord_i,
  input  logic signed [vct_pkg::CoordW-1:0]  target_coord_i,
  input  logic signed [vct_pkg::CoordW-1:0]  dir_coord_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               in_sight_o,
  output logic                               coincident_o,
  output logic                               too_long_o
);
  import vct_pkg::*;

  seq_ctrl_t ctrl;
  logic      out_free;
  logic      in_fire;

  logic [CoordW-1:0]        cos_q;
  logic signed [CoordW-1:0] obs_q, tgt_q, dir_q;
  logic                     last_q;
  logic signed [DiffW-1:0]  diff;
  logic signed [DiffW-1:0]  d_q;
  logic                     skip_q;
  logic                     cnt_full;
  logic                     elem_skip;

  logic signed [DotW-1:0]   dot_q;
  logic [SqW-1:0]           sq_q;
  logic [CntW-1:0]          cnt_q;
  logic                     ovf_q;
  logic [DotW-1:0]          dmag_q;
  logic [C2W-1:0]           c2_q;
  logic [AccW-1:0]          lhs_q, rhs_q;
  logic [MagW-1:0]          cmag;

  logic [DotPadW-1:0]       dmag_pad;
  logic [SqPadW-1:0]        sq_pad;
  logic [C2PadW-1:0]        c2_pad;

  logic signed [MulW-1:0]   mul_a, mul_b;
  mul_tag_t                 issue_tag;
  logic signed [ProdW-1:0]  prod;
  mul_tag_t                 prod_tag;
  logic [ShiftW-1:0]        shift;
  logic [AccW-1:0]          part;

  logic out_valid_q, in_sight_q, coincident_q, too_long_q;
  logic dot_neg, dot_zero, cone;

  vct_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  vct_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (issue_tag),
    .prod_o (prod),
    .tag_o  (prod_tag)
  );

  assign in_ready_o = ctrl.in_ready;
  assign in_fire    = in_valid_i && ctrl.in_ready;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= '0;
    end else if (cos_half_angle_we_i) begin
      cos_q <= cos_half_angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (in_fire) begin
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      obs_q <= observer_coord_i;
      tgt_q <= target_coord_i;
      dir_q <= dir_coord_i;
    end
  end

  assign diff      = DiffW'(tgt_q) - DiffW'(obs_q);
  assign cnt_full  = cnt_q >= CntW'(MaxDim);
  assign elem_skip = (ctrl.op == OP_DOT) ? cnt_full : skip_q;
  assign cmag      = cos_q[CoordW-1] ? (~cos_q + MagW'(1)) : cos_q;

  assign dmag_pad = DotPadW'(dmag_q);
  assign sq_pad   = SqPadW'(sq_q);
  assign c2_pad   = C2PadW'(c2_q);

  // operand select for the shared multiplier
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    issue_tag = '{op: OP_NONE, sum: '0};
    case (ctrl.op)
      OP_DOT: begin
        mul_a         = MulW'(diff);
        mul_b         = MulW'(dir_q);
        issue_tag.op  = elem_skip ? OP_NONE : OP_DOT;
      end
      OP_SQ: begin
        mul_a         = MulW'(d_q);
        mul_b         = MulW'(d_q);
        issue_tag.op  = elem_skip ? OP_NONE : OP_SQ;
      end
      OP_C2: begin
        mul_a         = MulW'(cmag);
        mul_b         = MulW'(cmag);
        issue_tag.op  = OP_C2;
      end
      OP_LHS: begin
        mul_a         = {1'b0, dmag_pad[ctrl.a_idx*LimbW +: LimbW]};
        mul_b         = {1'b0, dmag_pad[ctrl.b_idx*LimbW +: LimbW]};
        issue_tag.op  = OP_LHS;
        issue_tag.sum = SumW'(ctrl.a_idx) + SumW'(ctrl.b_idx);
      end
      OP_RHS: begin
        mul_a         = {1'b0, c2_pad[ctrl.a_idx*LimbW +: LimbW]};
        mul_b         = {1'b0, sq_pad[ctrl.b_idx*LimbW +: LimbW]};
        issue_tag.op  = OP_RHS;
        issue_tag.sum = SumW'(ctrl.a_idx) + SumW'(ctrl.b_idx);
      end
      default: ;
    endcase
  end

  assign shift = ShiftW'(prod_tag.sum * LimbW);
  assign part  = AccW'($unsigned(prod)) << shift;

  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_DOT) begin
      d_q    <= diff;
      skip_q <= cnt_full;
    end
    if (ctrl.prep) begin
      dmag_q <= dot_q[DotW-1] ? (~dot_q + DotW'(1)) : dot_q;
    end
    if (prod_tag.op == OP_C2) begin
      c2_q <= C2W'($unsigned(prod));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      lhs_q <= '0;
      rhs_q <= '0;
    end else if (ctrl.finish) begin
      dot_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      lhs_q <= '0;
      rhs_q <= '0;
    end else begin
      case (prod_tag.op)
        OP_DOT:  dot_q <= dot_q + DotW'(prod);
        OP_SQ:   sq_q  <= sq_q + SqW'($unsigned(prod));
        OP_LHS:  lhs_q <= lhs_q + part;
        OP_RHS:  rhs_q <= rhs_q + part;
        default: ;
      endcase
      if (ctrl.op == OP_DOT) begin
        if (cnt_full) ovf_q <= 1'b1;
        else cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // sign cases of dot > cos * |d| on squared magnitudes
  assign dot_neg  = dot_q[DotW-1];
  assign dot_zero = (dot_q == '0);
  assign cone     = cos_q[CoordW-1] ? (!dot_neg || (rhs_q > lhs_q))
                                    : (!dot_neg && !dot_zero && (lhs_q > rhs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      too_long_q   <= ovf_q;
      coincident_q <= !ovf_q && (sq_q == '0);
      in_sight_q   <= !ovf_q && (sq_q != '0) && cone;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_sight_o   = in_sight_q;
  assign coincident_o = coincident_q;
  assign too_long_o   = too_long_q;

endmodule

// ----- sv/vct_mul.sv -----
// shared registered 18x18 signed multiplier with a tag that follows the product
module vct_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [vct_pkg::MulW-1:0]    a_i,
  input  logic signed [vct_pkg::MulW-1:0]    b_i,
  input  vct_pkg::mul_tag_t                  tag_i,
  output logic signed [vct_pkg::ProdW-1:0]   prod_o,
  output vct_pkg::mul_tag_t                  tag_o
);
  import vct_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;
  mul_tag_t                tag_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{op: OP_NONE, sum: '0};
    end else begin
      tag_q <= tag_i;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

// ----- sv/vct_seq.sv -----
// sequencer for per-coordinate products and the final wide compare
module vct_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  input  logic                out_free_i,
  output vct_pkg::seq_ctrl_t  ctrl_o
);
  import vct_pkg::*;

  state_e          state_d, state_q;
  logic [IdxW-1:0] a_idx_d, a_idx_q;
  logic [IdxW-1:0] b_idx_d, b_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_idx_q <= '0;
      b_idx_q <= '0;
    end else begin
      state_q <= state_d;
      a_idx_q <= a_idx_d;
      b_idx_q <= b_idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DOT;
      end
      S_DOT: state_d = S_SQ;
      S_SQ: begin
        if (last_i) state_d = S_PREP;
        else if (in_valid_i) state_d = S_DOT;
        else state_d = S_IDLE;
      end
      S_PREP: state_d = S_LHS;
      S_LHS: begin
        if (a_idx_q == IdxW'(DotLimbs - 1) && b_idx_q == IdxW'(DotLimbs - 1)) begin
          state_d = S_RHS;
        end
      end
      S_RHS: begin
        if (a_idx_q == IdxW'(C2Limbs - 1) && b_idx_q == IdxW'(SqLimbs - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // limb pair counters
  always_comb begin
    a_idx_d = a_idx_q;
    b_idx_d = b_idx_q;
    unique case (state_q)
      S_LHS: begin
        if (b_idx_q == IdxW'(DotLimbs - 1)) begin
          b_idx_d = '0;
          a_idx_d = (a_idx_q == IdxW'(DotLimbs - 1)) ? '0 : a_idx_q + 1'b1;
        end else begin
          b_idx_d = b_idx_q + 1'b1;
        end
      end
      S_RHS: begin
        if (b_idx_q == IdxW'(SqLimbs - 1)) begin
          b_idx_d = '0;
          a_idx_d = (a_idx_q == IdxW'(C2Limbs - 1)) ? '0 : a_idx_q + 1'b1;
        end else begin
          b_idx_d = b_idx_q + 1'b1;
        end
      end
      default: begin
        a_idx_d = '0;
        b_idx_d = '0;
      end
    endcase
  end

  always_comb begin
    ctrl_o.a_idx    = a_idx_q;
    ctrl_o.b_idx    = b_idx_q;
    ctrl_o.in_ready = (state_q == S_IDLE) || ((state_q == S_SQ) && !last_i);
    ctrl_o.prep     = (state_q == S_PREP);
    ctrl_o.finish   = (state_q == S_DONE) && out_free_i;
    unique case (state_q)
      S_DOT:   ctrl_o.op = OP_DOT;
      S_SQ:    ctrl_o.op = OP_SQ;
      S_PREP:  ctrl_o.op = OP_C2;
      S_LHS:   ctrl_o.op = OP_LHS;
      S_RHS:   ctrl_o.op = OP_RHS;
      default: ctrl_o.op = OP_NONE;
    endcase
  end

endmodule
